FILE: rtl/core/lsbp_pkg.sv
`timescale 1ns / 1ps
// lsbp_pkg: types and constants shared by the lsb-first bit packer modules
// no dependencies

package lsbp_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned CountW    = 7;
  localparam int unsigned OpW       = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 48;
  localparam int unsigned EmittedW  = 45;
  localparam int unsigned PendW     = 7;
  localparam int unsigned PendCntW  = 3;
  localparam int unsigned NumBytesW = 4;
  localparam int unsigned MaxCount  = 64;
  localparam int unsigned SDataW    = 72;
  localparam int unsigned MDataW    = 56;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [OpW-1:0] {
    OpAppend = 2'd0,
    OpAlign  = 2'd1,
    OpClear  = 2'd2
  } op_e;

  // one classified request: its bytes, how many, and the position after it
  typedef struct packed {
    logic [ValueW-1:0]    bytes;
    logic [NumBytesW-1:0] num_bytes;
    logic [PosW-1:0]      bit_pos;
  } job_t;

endpackage

FILE: rtl/core/lsbp_front.sv
`timescale 1ns / 1ps
// lsbp_front: accepts requests, keeps the pending bits and byte count,
// and turns each request into a job; uses lsbp_pkg

module lsbp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [lsbp_pkg::OpW-1:0]    opcode_i,
  input  logic [lsbp_pkg::ValueW-1:0] field_value_i,
  input  logic [lsbp_pkg::CountW-1:0] bit_count_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output lsbp_pkg::job_t              job_o
);
  import lsbp_pkg::*;

  logic [PendW-1:0]    pend_q, pend_d;
  logic [PendCntW-1:0] pcnt_q, pcnt_d;
  logic [EmittedW-1:0] emitted_q, emitted_d;
  logic                accept;

  logic [CountW-1:0]        n_sat;
  logic [ValueW-1:0]        val_m;
  logic [ValueW+PendW-1:0]  cat;
  logic [CountW-1:0]        total;
  logic [NumBytesW-1:0]     nb;

  assign req_ready_o = job_ready_i;
  assign job_valid_o = req_valid_i;
  assign accept      = req_valid_i & job_ready_i;

  always_comb begin
    // saturate oversize counts
    n_sat = (bit_count_i > CountW'(MaxCount)) ? CountW'(MaxCount) : bit_count_i;
    if (n_sat[CountW-1]) begin
      val_m = field_value_i;
    end else begin
      val_m = field_value_i & ~({ValueW{1'b1}} << n_sat[CountW-2:0]);
    end
    cat   = ({{PendW{1'b0}}, val_m} << pcnt_q) | {{ValueW{1'b0}}, pend_q};
    total = CountW'(pcnt_q) + n_sat;

    pend_d = pend_q;
    pcnt_d = pcnt_q;
    nb     = '0;
    job_o.bytes = '0;
    case (op_e'(opcode_i))
      OpAppend: begin
        nb          = total[CountW-1:3];
        job_o.bytes = cat[ValueW-1:0];
        pcnt_d      = total[2:0];
        pend_d      = PendW'(cat >> {nb, 3'b000});
      end
      OpAlign: begin
        nb          = (pcnt_q != '0) ? NumBytesW'(1) : '0;
        job_o.bytes = {{(ValueW-PendW){1'b0}}, pend_q};
        pend_d      = '0;
        pcnt_d      = '0;
      end
      OpClear: begin
        pend_d = '0;
        pcnt_d = '0;
      end
      default: begin
      end
    endcase
    if (op_e'(opcode_i) == OpClear) begin
      emitted_d = '0;
    end else begin
      emitted_d = emitted_q + EmittedW'(nb);
    end
    job_o.num_bytes = nb;
    job_o.bit_pos   = {emitted_d, pcnt_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      pcnt_q    <= '0;
      emitted_q <= '0;
    end else if (accept) begin
      pend_q    <= pend_d;
      pcnt_q    <= pcnt_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

FILE: rtl/core/lsbp_queue.sv
`timescale 1ns / 1ps
// lsbp_queue: short job queue between the front and back parts
// uses lsbp_pkg for the job type

module lsbp_queue #(
  parameter int unsigned Depth = lsbp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsbp_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lsbp_pkg::job_t pop_job_o
);
  import lsbp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_job_o    = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lsbp_back.sv
`timescale 1ns / 1ps
// lsbp_back: plays out one job as a run of results, one byte per cycle while the receiver is ready
// uses lsbp_pkg for the job type and widths

module lsbp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  output logic                       job_ready_o,
  input  lsbp_pkg::job_t             job_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [lsbp_pkg::ByteW-1:0] out_byte_o,
  output logic                       byte_valid_o,
  output logic                       last_of_run_o,
  output logic [lsbp_pkg::PosW-1:0]  bit_position_o
);
  import lsbp_pkg::*;

  logic                 busy_q;
  logic [ValueW-1:0]    bytes_q;
  logic [NumBytesW-1:0] left_q;
  logic                 has_bytes_q;
  logic [PosW-1:0]      pos_q;
  logic                 last, step, load;

  assign last = (left_q == NumBytesW'(1));
  assign step = busy_q & res_ready_i;
  assign load = job_valid_i & (!busy_q | (step & last));
  assign job_ready_o = !busy_q | (step & last);

  assign res_valid_o    = busy_q;
  // status-only results carry a zero byte
  assign out_byte_o     = has_bytes_q ? bytes_q[ByteW-1:0] : '0;
  assign byte_valid_o   = has_bytes_q;
  assign last_of_run_o  = last;
  assign bit_position_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (step && last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q     <= job_i.bytes;
      has_bytes_q <= (job_i.num_bytes != '0);
      left_q      <= (job_i.num_bytes != '0) ? job_i.num_bytes : NumBytesW'(1);
      pos_q       <= job_i.bit_pos;
    end else if (step) begin
      bytes_q <= bytes_q >> ByteW;
      left_q  <= left_q - NumBytesW'(1);
    end
  end

endmodule

FILE: rtl/core/lsb_first_bit_packer.sv
`timescale 1ns / 1ps
// lsb_first_bit_packer: top level of the lsb-first bit packer
// uses lsbp_pkg, lsbp_front, lsbp_queue and lsbp_back
//
// usage
//   requests enter on the s_axis channel: tuser carries the opcode (append,
//   align to byte, clear), tdata the value and the bit count (0..64, larger
//   counts saturate to 64). appended bits stack above the pending bits, lsb
//   first, and every completed byte leaves on the m_axis channel
//   results on m_axis carry one byte each (tuser high) or a single status
//   result with tuser low when a request completes no byte; tlast marks the
//   final result of each request, and tdata also carries the running bit
//   position after that request, wrapping at 2^48
//   a request taken on s_axis is written into the job queue, then loaded
//   into the back part once it is free; its registers drive m_axis
//   throughput: the front accepts a request every cycle while the job queue
//   has room; the back emits one result per cycle while the receiver is
//   ready, and a request gives max(bytes, 1) results (one to eight). the
//   byte-per-cycle output port sets the sustained rate
//   reset empties the queue and the output, clears pending bits and sets
//   the position to zero. when the receiver stalls the current result holds,
//   and the front keeps accepting until the queue fills

module lsb_first_bit_packer #(
  parameter int unsigned QueueDepth = lsbp_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [63:0] field_value, [70:64] bit_count, [71] zero
  input  logic [lsbp_pkg::SDataW-1:0] s_axis_tdata_i,
  // [1:0] opcode
  input  logic [lsbp_pkg::OpW-1:0]    s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] out_byte, [55:8] bit_position
  output logic [lsbp_pkg::MDataW-1:0] m_axis_tdata_o,
  // [0] byte_valid
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);
  import lsbp_pkg::*;

  // front to queue
  logic job_in_valid, job_in_ready;
  job_t job_in;
  // queue to back
  logic job_out_valid, job_out_ready;
  job_t job_out;

  logic [ByteW-1:0] out_byte;
  logic [PosW-1:0]  bit_position;

  lsbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid_i),
    .req_ready_o   (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i),
    .field_value_i (s_axis_tdata_i[ValueW-1:0]),
    .bit_count_i   (s_axis_tdata_i[ValueW+CountW-1:ValueW]),
    .job_valid_o   (job_in_valid),
    .job_ready_i   (job_in_ready),
    .job_o         (job_in)
  );

  lsbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_in_valid),
    .push_ready_o (job_in_ready),
    .push_job_i   (job_in),
    .pop_valid_o  (job_out_valid),
    .pop_ready_i  (job_out_ready),
    .pop_job_o    (job_out)
  );

  lsbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_out_valid),
    .job_ready_o    (job_out_ready),
    .job_i          (job_out),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .out_byte_o     (out_byte),
    .byte_valid_o   (m_axis_tuser_o),
    .last_of_run_o  (m_axis_tlast_o),
    .bit_position_o (bit_position)
  );

  assign m_axis_tdata_o = {bit_position, out_byte};

endmodule
